// ----- rtl/pvkf_pkg.sv -----
// pvkf_pkg: shared types, codes and helpers for the position/velocity Kalman filter.
// Used by pvkf_alu, position_velocity_kalman_filter_unit and its bench.
package pvkf_pkg;

    // input opcodes
    localparam logic [1:0] OP_ACCEL = 2'd0;
    localparam logic [1:0] OP_POS   = 2'd1;
    localparam logic [1:0] OP_VEL   = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_POS_NOISE  = 2'd0;
    localparam logic [1:0] REG_VEL_NOISE  = 2'd1;
    localparam logic [1:0] REG_PROC_NOISE = 2'd2;
    localparam logic [1:0] REG_INIT_VAR   = 2'd3;

    localparam logic [30:0] CFG_RESET = 31'd65536;

    // accumulator width: holds a sum of five saturated 32-bit terms
    localparam int ACC_W = 36;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LD   = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic       mul_en;
        logic       half;    // product rounded for dt squared over two
        logic [1:0] acc_op;
    } t_alu_ctl;

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] y;
        if (x > 36'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -36'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// ----- rtl/pvkf_alu.sv -----
// pvkf_alu: shared fixed-point multiplier (rounded, saturated) and accumulator.
// Depends on pvkf_pkg.
module pvkf_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  pvkf_pkg::t_alu_ctl               i_ctl,
    input  logic signed [31:0]               i_a,
    input  logic signed [31:0]               i_b,
    input  logic signed [31:0]               i_x,
    output logic signed [31:0]               o_m,
    output logic signed [pvkf_pkg::ACC_W-1:0] o_acc
);

    logic signed [63:0] prod;
    logic signed [64:0] rsum;
    logic signed [64:0] shifted;
    logic signed [31:0] m_sat;
    logic signed [pvkf_pkg::ACC_W-1:0] x_ext;
    logic signed [31:0] r_m;
    logic signed [pvkf_pkg::ACC_W-1:0] r_acc;

    always_comb begin
        prod = i_a * i_b;
        if (i_ctl.half) begin
            rsum    = 65'(prod) + (65'sd1 <<< FRAC_BITS);
            shifted = rsum >>> (FRAC_BITS + 1);
        end else begin
            rsum    = 65'(prod) + (65'sd1 <<< (FRAC_BITS - 1));
            shifted = rsum >>> FRAC_BITS;
        end
        if (shifted > 65'sd2147483647) begin
            m_sat = 32'sh7FFF_FFFF;
        end else if (shifted < -65'sd2147483648) begin
            m_sat = 32'sh8000_0000;
        end else begin
            m_sat = shifted[31:0];
        end
        x_ext = pvkf_pkg::ACC_W'(i_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_m <= m_sat;
        end
        unique case (i_ctl.acc_op)
            pvkf_pkg::ACC_HOLD: r_acc <= r_acc;
            pvkf_pkg::ACC_LD:   r_acc <= x_ext;
            pvkf_pkg::ACC_ADD:  r_acc <= r_acc + x_ext;
            pvkf_pkg::ACC_SUB:  r_acc <= r_acc - x_ext;
            default:            r_acc <= r_acc;
        endcase
    end

    assign o_m   = r_m;
    assign o_acc = r_acc;

endmodule

// ----- rtl/pvkf_div.sv -----
// pvkf_div: radix-2 restoring divider for the Kalman gain, (num * 2^F) / den.
// One quotient bit per cycle, truncated toward zero, saturated.
module pvkf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_busy,
    output logic signed [31:0] o_q
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [31:0]   mag;
    logic [32:0]   rem_sh;
    logic [33:0]   diff;

    always_comb begin
        mag    = i_num[31] ? (~i_num + 32'd1) : i_num;
        rem_sh = {r_rem, r_quo[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= NW'(mag) << FRAC_BITS;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            if (!diff[33]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_q = (r_quo > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : r_quo[31:0];
        end else begin
            o_q = (r_quo > NW'(32'h8000_0000)) ? 32'sh8000_0000 : (~r_quo[31:0] + 32'd1);
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/position_velocity_kalman_filter_unit.sv -----
// position_velocity_kalman_filter_unit: top level, sequencer, state and output register.
// Depends on pvkf_pkg, pvkf_alu and pvkf_div.

// Three-axis constant-velocity Kalman filter in signed fixed point (FRAC_BITS fraction
// bits). Every acceleration or measurement item runs through one shared
// multiplier/accumulator and one divider under a step sequencer, axis after axis, and
// the input is not ready while it works. An initialize item is applied as it is
// accepted and gives no result. An acceleration item runs only the predict, 22
// multiply/accumulate steps per axis. A position or velocity measurement adds the
// update per axis, which waits mostly on the two bit-serial gain divisions. The
// result sits in an output register, so a new item is taken while it waits; a finished
// item waits for that register to be free. Configuration writes take effect at once
// and belong to idle time.
module position_velocity_kalman_filter_unit #(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [19:0]        i_delta_time,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_pos_var_x,
    output logic signed [31:0] o_pos_var_y,
    output logic signed [31:0] o_pos_var_z,
    output logic signed [31:0] o_vel_var_x,
    output logic signed [31:0] o_vel_var_y,
    output logic signed [31:0] o_vel_var_z
);

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GLOB  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_PRED  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_STORE = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // destinations of the registered product
    localparam logic [3:0] MD_NONE = 4'd0;
    localparam logic [3:0] MD_T0   = 4'd1;
    localparam logic [3:0] MD_T1   = 4'd2;
    localparam logic [3:0] MD_T2   = 4'd3;
    localparam logic [3:0] MD_T3   = 4'd4;
    localparam logic [3:0] MD_T4   = 4'd5;
    localparam logic [3:0] MD_T5   = 4'd6;
    localparam logic [3:0] MD_H    = 4'd7;
    localparam logic [3:0] MD_Q1   = 4'd8;
    localparam logic [3:0] MD_Q2   = 4'd9;

    // destinations of the saturated accumulator
    localparam logic [2:0] SD_NONE = 3'd0;
    localparam logic [2:0] SD_P    = 3'd1;
    localparam logic [2:0] SD_V    = 3'd2;
    localparam logic [2:0] SD_PP   = 3'd3;
    localparam logic [2:0] SD_PV   = 3'd4;
    localparam logic [2:0] SD_VV   = 3'd5;
    localparam logic [2:0] SD_E    = 3'd6;

    // per-axis state
    logic signed [31:0] r_pos  [AXES];
    logic signed [31:0] r_vel  [AXES];
    logic signed [31:0] r_cpp  [AXES];
    logic signed [31:0] r_cpv  [AXES];
    logic signed [31:0] r_cvv  [AXES];
    logic signed [31:0] r_lacc [AXES];

    logic [30:0] r_rp, r_rv, r_sq, r_iv;

    logic [1:0]         r_op;
    logic [19:0]        r_dt;
    logic signed [31:0] r_val [3];
    logic signed [31:0] r_h, r_q1, r_q2;
    logic signed [31:0] r_p, r_v, r_pp, r_pv, r_vv, r_a;
    logic signed [31:0] r_t [6];
    logic signed [31:0] r_k1, r_k2, r_e;
    logic [31:0]        r_s;

    logic [2:0]     r_state, n_state;
    logic [4:0]     r_step, n_step;
    logic [AXW-1:0] r_axis, n_axis;
    logic           r_out_valid;

    pvkf_pkg::t_alu_ctl alu_ctl;
    logic signed [31:0] alu_a, alu_b, alu_x, alu_m;
    logic signed [pvkf_pkg::ACC_W-1:0] alu_acc;
    logic signed [31:0] acc_sat;

    logic               div_start, div_busy;
    logic signed [31:0] div_num, div_q;
    logic [31:0]        div_den;

    logic [3:0] md;
    logic [2:0] sd;
    logic       s_we, k1_we, k2_we, out_load;
    logic       in_fire, is_vel;
    logic signed [31:0] dt32, in_val [3];

    assign in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign is_vel    = (r_op == pvkf_pkg::OP_VEL);
    assign dt32      = signed'({12'd0, r_dt});
    assign acc_sat   = pvkf_pkg::sat_acc(alu_acc);
    assign in_val[0] = i_value_x;
    assign in_val[1] = i_value_y;
    assign in_val[2] = i_value_z;

    pvkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk (i_clk),
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_x   (alu_x),
        .o_m   (alu_m),
        .o_acc (alu_acc)
    );

    pvkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    // sequencer: at most one multiply and one accumulate per step
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_axis    = r_axis;
        alu_ctl   = '0;
        alu_a     = '0;
        alu_b     = '0;
        alu_x     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        md        = MD_NONE;
        sd        = SD_NONE;
        s_we      = 1'b0;
        k1_we     = 1'b0;
        k2_we     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_opcode != pvkf_pkg::OP_INIT) begin
                    n_state = S_GLOB;
                    n_step  = '0;
                end
            end
            S_GLOB: begin
                n_step = r_step + 5'd1;
                unique case (r_step)
                    5'd0: begin
                        alu_ctl.mul_en = 1'b1;
                        alu_ctl.half   = 1'b1;
                        alu_a = dt32;
                        alu_b = dt32;
                    end
                    5'd1: begin
                        md = MD_H;
                        alu_ctl.mul_en = 1'b1;
                        alu_a = signed'({1'b0, r_sq});
                        alu_b = alu_m;
                    end
                    5'd2: begin
                        md = MD_Q1;
                        alu_ctl.mul_en = 1'b1;
                        alu_a = alu_m;
                        alu_b = dt32;
                    end
                    default: begin
                        md      = MD_Q2;
                        n_state = S_LOAD;
                        n_axis  = '0;
                    end
                endcase
            end
            S_LOAD: begin
                n_state = S_PRED;
                n_step  = '0;
            end
            S_PRED: begin
                n_step = r_step + 5'd1;
                unique case (r_step)
                    5'd0: begin
                        alu_ctl.mul_en = 1'b1; alu_a = dt32; alu_b = r_v;
                    end
                    5'd1: begin
                        md = MD_T0; alu_ctl.mul_en = 1'b1; alu_a = r_h; alu_b = r_a;
                    end
                    5'd2: begin
                        md = MD_T1; alu_ctl.mul_en = 1'b1; alu_a = dt32; alu_b = r_a;
                    end
                    5'd3: begin
                        md = MD_T2; alu_ctl.mul_en = 1'b1; alu_a = dt32; alu_b = r_pv;
                    end
                    5'd4: begin
                        md = MD_T3; alu_ctl.mul_en = 1'b1; alu_a = dt32; alu_b = r_vv;
                    end
                    5'd5: begin
                        md = MD_T4; alu_ctl.mul_en = 1'b1; alu_a = dt32; alu_b = alu_m;
                    end
                    5'd6: begin
                        md = MD_T5; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_p;
                    end
                    5'd7:  begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[0]; end
                    5'd8:  begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[1]; end
                    5'd9:  begin sd = SD_P; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_v; end
                    5'd10: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[2]; end
                    5'd11: begin sd = SD_V; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_pp; end
                    5'd12: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[3]; end
                    5'd13: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[3]; end
                    5'd14: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[5]; end
                    5'd15: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_q2; end
                    5'd16: begin sd = SD_PP; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_pv; end
                    5'd17: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[4]; end
                    5'd18: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_q1; end
                    5'd19: begin sd = SD_PV; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_vv; end
                    5'd20: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_q1; end
                    default: begin
                        sd     = SD_VV;
                        n_step = '0;
                        n_state = (r_op == pvkf_pkg::OP_ACCEL) ? S_STORE : S_UPD;
                    end
                endcase
            end
            S_UPD: begin
                n_step = r_step + 5'd1;
                unique case (r_step)
                    5'd0: begin
                        alu_ctl.acc_op = pvkf_pkg::ACC_LD;
                        alu_x = is_vel ? r_vv : r_pp;
                    end
                    5'd1: begin
                        alu_ctl.acc_op = pvkf_pkg::ACC_ADD;
                        alu_x = is_vel ? signed'({1'b0, r_rv}) : signed'({1'b0, r_rp});
                    end
                    5'd2: begin
                        // innovation variance not positive: keep the prediction
                        if (alu_acc <= 36'sd0) begin
                            n_state = S_STORE;
                        end else begin
                            div_start = 1'b1;
                            div_num   = is_vel ? r_pv : r_pp;
                            div_den   = alu_acc[31:0];
                            s_we      = 1'b1;
                            alu_ctl.acc_op = pvkf_pkg::ACC_LD;
                            alu_x = r_val[r_axis];
                        end
                    end
                    5'd3: begin
                        alu_ctl.acc_op = pvkf_pkg::ACC_SUB;
                        alu_x = is_vel ? r_v : r_p;
                    end
                    5'd4: begin
                        sd = SD_E;
                        if (div_busy) begin
                            n_step = r_step;
                        end else begin
                            k1_we     = 1'b1;
                            div_start = 1'b1;
                            div_num   = is_vel ? r_vv : r_pv;
                            div_den   = r_s;
                        end
                    end
                    5'd5: begin
                        if (div_busy) begin
                            n_step = r_step;
                        end else begin
                            k2_we = 1'b1;
                        end
                    end
                    5'd6: begin
                        alu_ctl.mul_en = 1'b1; alu_a = r_k1; alu_b = r_e;
                    end
                    5'd7: begin
                        md = MD_T0; alu_ctl.mul_en = 1'b1; alu_a = r_k2; alu_b = r_e;
                    end
                    5'd8: begin
                        md = MD_T1; alu_ctl.mul_en = 1'b1;
                        alu_a = r_k1; alu_b = is_vel ? r_pv : r_pp;
                    end
                    5'd9: begin
                        md = MD_T2; alu_ctl.mul_en = 1'b1;
                        alu_a = r_k1; alu_b = is_vel ? r_vv : r_pv;
                    end
                    5'd10: begin
                        md = MD_T3; alu_ctl.mul_en = 1'b1;
                        alu_a = r_k2; alu_b = is_vel ? r_vv : r_pv;
                        alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_p;
                    end
                    5'd11: begin
                        md = MD_T4; alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[0];
                    end
                    5'd12: begin sd = SD_P; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_v; end
                    5'd13: begin alu_ctl.acc_op = pvkf_pkg::ACC_ADD; alu_x = r_t[1]; end
                    5'd14: begin sd = SD_V; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_pp; end
                    5'd15: begin alu_ctl.acc_op = pvkf_pkg::ACC_SUB; alu_x = r_t[2]; end
                    5'd16: begin sd = SD_PP; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_pv; end
                    5'd17: begin alu_ctl.acc_op = pvkf_pkg::ACC_SUB; alu_x = r_t[3]; end
                    5'd18: begin sd = SD_PV; alu_ctl.acc_op = pvkf_pkg::ACC_LD; alu_x = r_vv; end
                    5'd19: begin alu_ctl.acc_op = pvkf_pkg::ACC_SUB; alu_x = r_t[4]; end
                    default: begin
                        sd      = SD_VV;
                        n_state = S_STORE;
                    end
                endcase
            end
            S_STORE: begin
                if (r_axis == AXW'(AXES - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers and per-axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= pvkf_pkg::CFG_RESET;
            r_rv <= pvkf_pkg::CFG_RESET;
            r_sq <= pvkf_pkg::CFG_RESET;
            r_iv <= pvkf_pkg::CFG_RESET;
            for (int k = 0; k < AXES; k++) begin
                r_pos[k]  <= '0;
                r_vel[k]  <= '0;
                r_cpp[k]  <= ONE_Q;
                r_cpv[k]  <= '0;
                r_cvv[k]  <= ONE_Q;
                r_lacc[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pvkf_pkg::REG_POS_NOISE:  r_rp <= i_cfg_data;
                    pvkf_pkg::REG_VEL_NOISE:  r_rv <= i_cfg_data;
                    pvkf_pkg::REG_PROC_NOISE: r_sq <= i_cfg_data;
                    pvkf_pkg::REG_INIT_VAR:   r_iv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire && i_opcode == pvkf_pkg::OP_INIT) begin
                for (int k = 0; k < AXES; k++) begin
                    r_pos[k] <= in_val[k];
                    r_vel[k] <= '0;
                    r_cpp[k] <= signed'({1'b0, r_iv});
                    r_cpv[k] <= '0;
                    r_cvv[k] <= signed'({1'b0, r_iv});
                end
            end
            if (in_fire && i_opcode == pvkf_pkg::OP_ACCEL) begin
                for (int k = 0; k < AXES; k++) begin
                    r_lacc[k] <= in_val[k];
                end
            end
            if (r_state == S_STORE) begin
                r_pos[r_axis] <= r_p;
                r_vel[r_axis] <= r_v;
                r_cpp[r_axis] <= r_pp;
                r_cpv[r_axis] <= r_pv;
                r_cvv[r_axis] <= r_vv;
            end
        end
    end

    // working registers of the axis in progress
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= i_opcode;
            r_dt     <= i_delta_time;
            r_val[0] <= i_value_x;
            r_val[1] <= i_value_y;
            r_val[2] <= i_value_z;
        end
        if (r_state == S_LOAD) begin
            r_p  <= r_pos[r_axis];
            r_v  <= r_vel[r_axis];
            r_pp <= r_cpp[r_axis];
            r_pv <= r_cpv[r_axis];
            r_vv <= r_cvv[r_axis];
            r_a  <= r_lacc[r_axis];
        end else begin
            unique case (sd)
                SD_P:    r_p  <= acc_sat;
                SD_V:    r_v  <= acc_sat;
                SD_PP:   r_pp <= acc_sat;
                SD_PV:   r_pv <= acc_sat;
                SD_VV:   r_vv <= acc_sat;
                SD_E:    r_e  <= acc_sat;
                default: ;
            endcase
        end
        unique case (md)
            MD_T0:   r_t[0] <= alu_m;
            MD_T1:   r_t[1] <= alu_m;
            MD_T2:   r_t[2] <= alu_m;
            MD_T3:   r_t[3] <= alu_m;
            MD_T4:   r_t[4] <= alu_m;
            MD_T5:   r_t[5] <= alu_m;
            MD_H:    r_h    <= alu_m;
            MD_Q1:   r_q1   <= alu_m;
            MD_Q2:   r_q2   <= alu_m;
            default: ;
        endcase
        if (s_we) begin
            r_s <= alu_acc[31:0];
        end
        if (k1_we) begin
            r_k1 <= div_q;
        end
        if (k2_we) begin
            r_k2 <= div_q;
        end
    end

    // output register; axes beyond AXES read as zero
    logic signed [31:0] out_pos [3];
    logic signed [31:0] out_vel [3];
    logic signed [31:0] out_ppv [3];
    logic signed [31:0] out_vvv [3];

    for (genvar g = 0; g < 3; g++) begin : g_out
        if (g < AXES) begin : g_on
            logic signed [31:0] r_opos, r_ovel, r_oppv, r_ovvv;
            always_ff @(posedge i_clk) begin
                if (out_load) begin
                    r_opos <= r_pos[g];
                    r_ovel <= r_vel[g];
                    r_oppv <= r_cpp[g];
                    r_ovvv <= r_cvv[g];
                end
            end
            assign out_pos[g] = r_opos;
            assign out_vel[g] = r_ovel;
            assign out_ppv[g] = r_oppv;
            assign out_vvv[g] = r_ovvv;
        end else begin : g_off
            assign out_pos[g] = '0;
            assign out_vel[g] = '0;
            assign out_ppv[g] = '0;
            assign out_vvv[g] = '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = out_pos[0];
    assign o_pos_y     = out_pos[1];
    assign o_pos_z     = out_pos[2];
    assign o_vel_x     = out_vel[0];
    assign o_vel_y     = out_vel[1];
    assign o_vel_z     = out_vel[2];
    assign o_pos_var_x = out_ppv[0];
    assign o_pos_var_y = out_ppv[1];
    assign o_pos_var_z = out_ppv[2];
    assign o_vel_var_x = out_vvv[0];
    assign o_vel_var_y = out_vvv[1];
    assign o_vel_var_z = out_vvv[2];

`ifndef ASSERT_OFF
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("gain division started while divider busy");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_axis) <= AXES - 1)
        else $error("axis counter out of range");

    a_item_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode != pvkf_pkg::OP_INIT) |=> (r_state == S_GLOB))
        else $error("accepted item did not start the sequence");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ----- bench/tb_position_velocity_kalman_filter_unit.sv -----
// tb_position_velocity_kalman_filter_unit: self-checking bench for the three-axis Kalman filter.
// Depends on pvkf_pkg and position_velocity_kalman_filter_unit; predicts each estimate in 64-bit math.
module tb_position_velocity_kalman_filter_unit;

    localparam int FRAC = 16;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [19:0]        dt;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_item;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] pvar [3];
        logic signed [31:0] vvar [3];
    } t_estimate;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = '0;
    logic [19:0] delta_time = '0;
    logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic signed [31:0] pos_var_x, pos_var_y, pos_var_z, vel_var_x, vel_var_y, vel_var_z;

    position_velocity_kalman_filter_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_delta_time(delta_time),
        .i_value_x(value_x), .i_value_y(value_y), .i_value_z(value_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_pos_z(pos_z),
        .o_vel_x(vel_x), .o_vel_y(vel_y), .o_vel_z(vel_z),
        .o_pos_var_x(pos_var_x), .o_pos_var_y(pos_var_y), .o_pos_var_z(pos_var_z),
        .o_vel_var_x(vel_var_x), .o_vel_var_y(vel_var_y), .o_vel_var_z(vel_var_z)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    longint est_pos [3], est_vel [3], cov_pp [3], cov_pv [3], cov_vv [3], accel [3];
    longint pos_noise, vel_noise, proc_noise, init_var;

    t_item     pending_items [$];
    t_estimate expected_estimates [$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        in_accepted = 1'b0;

    function automatic longint clamp32(longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        return clamp32((num * (64'sd1 <<< FRAC)) / den);
    endfunction

    task automatic filter_reset();
        for (int k = 0; k < 3; k++) begin
            est_pos[k] = 0; est_vel[k] = 0; cov_pp[k] = 65536;
            cov_pv[k] = 0; cov_vv[k] = 65536; accel[k] = 0;
        end
        pos_noise = 65536; vel_noise = 65536; proc_noise = 65536; init_var = 65536;
    endtask

    task automatic scalar_update(int k, longint y, bit is_vel);
        longint pp, pv, vv, s, k1, k2, e;
        pp = cov_pp[k]; pv = cov_pv[k]; vv = cov_vv[k];
        s = is_vel ? vv + vel_noise : pp + pos_noise;
        if (s <= 0) return;   // skip the update, keep the prediction
        if (is_vel) begin
            k1 = qdiv(pv, s); k2 = qdiv(vv, s); e = clamp32(y - est_vel[k]);
        end else begin
            k1 = qdiv(pp, s); k2 = qdiv(pv, s); e = clamp32(y - est_pos[k]);
        end
        est_pos[k] = clamp32(est_pos[k] + qmul(k1, e));
        est_vel[k] = clamp32(est_vel[k] + qmul(k2, e));
        if (is_vel) begin
            cov_pp[k] = clamp32(pp - qmul(k1, pv));
            cov_pv[k] = clamp32(pv - qmul(k1, vv));
            cov_vv[k] = clamp32(vv - qmul(k2, vv));
        end else begin
            cov_pp[k] = clamp32(pp - qmul(k1, pp));
            cov_pv[k] = clamp32(pv - qmul(k1, pv));
            cov_vv[k] = clamp32(vv - qmul(k2, pv));
        end
    endtask

    task automatic predict_estimate(t_item it);
        longint val [3];
        longint dt, h, q1, q2, p, v, a, pp, pv, vv;
        t_estimate est;
        val[0] = longint'(it.vx); val[1] = longint'(it.vy); val[2] = longint'(it.vz);
        if (it.opcode == pvkf_pkg::OP_INIT) begin
            for (int k = 0; k < 3; k++) begin
                est_pos[k] = val[k]; est_vel[k] = 0;
                cov_pp[k] = init_var; cov_pv[k] = 0; cov_vv[k] = init_var;
            end
            return;
        end
        if (it.opcode == pvkf_pkg::OP_ACCEL)
            for (int k = 0; k < 3; k++) accel[k] = val[k];
        dt = longint'(it.dt);
        h = clamp32((dt * dt + (64'sd1 <<< FRAC)) >>> (FRAC + 1));
        q1 = qmul(proc_noise, h);
        q2 = qmul(q1, dt);
        for (int k = 0; k < 3; k++) begin
            p = est_pos[k]; v = est_vel[k]; a = accel[k];
            pp = cov_pp[k]; pv = cov_pv[k]; vv = cov_vv[k];
            est_pos[k] = clamp32(p + qmul(dt, v) + qmul(h, a));
            est_vel[k] = clamp32(v + qmul(dt, a));
            cov_pp[k] = clamp32(pp + 2 * qmul(dt, pv) + qmul(dt, qmul(dt, vv)) + q2);
            cov_pv[k] = clamp32(pv + qmul(dt, vv) + q1);
            cov_vv[k] = clamp32(vv + q1);
            if (it.opcode == pvkf_pkg::OP_POS) scalar_update(k, val[k], 1'b0);
            else if (it.opcode == pvkf_pkg::OP_VEL) scalar_update(k, val[k], 1'b1);
        end
        for (int k = 0; k < 3; k++) begin
            est.pos[k] = 32'(est_pos[k]); est.vel[k] = 32'(est_vel[k]);
            est.pvar[k] = 32'(cov_pp[k]); est.vvar[k] = 32'(cov_vv[k]);
        end
        expected_estimates = {expected_estimates, est};
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // driver: hold the item until its transfer, then load the next or go idle
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_accepted) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    opcode <= it.opcode; delta_time <= it.dt;
                    value_x <= it.vx; value_y <= it.vy; value_z <= it.vz;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // prediction at input transfer, checking at output transfer
    always @(posedge clk) begin
        in_accepted = rst_n && in_valid && in_ready;
        if (in_accepted) begin
            predict_estimate('{opcode, delta_time, value_x, value_y, value_z});
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_estimates.size() == 0) begin
                report_mismatch("unexpected result", pos_x, 32'h0);
            end else begin
                t_estimate w;
                w = expected_estimates.pop_front();
                if (pos_x !== w.pos[0]) report_mismatch("pos_x", pos_x, w.pos[0]);
                if (pos_y !== w.pos[1]) report_mismatch("pos_y", pos_y, w.pos[1]);
                if (pos_z !== w.pos[2]) report_mismatch("pos_z", pos_z, w.pos[2]);
                if (vel_x !== w.vel[0]) report_mismatch("vel_x", vel_x, w.vel[0]);
                if (vel_y !== w.vel[1]) report_mismatch("vel_y", vel_y, w.vel[1]);
                if (vel_z !== w.vel[2]) report_mismatch("vel_z", vel_z, w.vel[2]);
                if (pos_var_x !== w.pvar[0]) report_mismatch("pos_var_x", pos_var_x, w.pvar[0]);
                if (pos_var_y !== w.pvar[1]) report_mismatch("pos_var_y", pos_var_y, w.pvar[1]);
                if (pos_var_z !== w.pvar[2]) report_mismatch("pos_var_z", pos_var_z, w.pvar[2]);
                if (vel_var_x !== w.vvar[0]) report_mismatch("vel_var_x", vel_var_x, w.vvar[0]);
                if (vel_var_y !== w.vvar[1]) report_mismatch("vel_var_y", vel_var_y, w.vvar[1]);
                if (vel_var_z !== w.vvar[2]) report_mismatch("vel_var_z", vel_var_z, w.vvar[2]);
            end
        end
    end

    function automatic logic signed [31:0] rand_value(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int r;
        r = $urandom_range(99);
        it.opcode = (r < 25) ? pvkf_pkg::OP_ACCEL : (r < 55) ? pvkf_pkg::OP_POS
                  : (r < 85) ? pvkf_pkg::OP_VEL : pvkf_pkg::OP_INIT;
        r = $urandom_range(99);
        it.dt = (r < 70) ? 20'($urandom_range(16'h2000)) : (r < 90) ? 20'($urandom_range(20'h2_0000))
              : 20'($urandom());
        r = ($urandom_range(99) < 80) ? 4 : $urandom_range(3);
        it.vx = rand_value(r);
        it.vy = rand_value(($urandom_range(99) < 80) ? 4 : $urandom_range(3));
        it.vz = rand_value(($urandom_range(99) < 80) ? 1 : $urandom_range(3));
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_estimates.size() > 0)
            @(posedge clk);
        // a trailing initialize item leaves no result behind
        repeat (400) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [30:0] data);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pvkf_pkg::REG_POS_NOISE:  pos_noise = longint'(data);
            pvkf_pkg::REG_VEL_NOISE:  vel_noise = longint'(data);
            pvkf_pkg::REG_PROC_NOISE: proc_noise = longint'(data);
            default:                  init_var = longint'(data);
        endcase
    endtask

    task automatic configure(logic [30:0] pn, logic [30:0] vn, logic [30:0] qn, logic [30:0] iv);
        write_register(pvkf_pkg::REG_POS_NOISE, pn);
        write_register(pvkf_pkg::REG_VEL_NOISE, vn);
        write_register(pvkf_pkg::REG_PROC_NOISE, qn);
        write_register(pvkf_pkg::REG_INIT_VAR, iv);
    endtask

    task automatic queue_item(logic [1:0] op, logic [19:0] dt, logic signed [31:0] vx,
                              logic signed [31:0] vy, logic signed [31:0] vz);
        t_item it;
        it.opcode = op; it.dt = dt; it.vx = vx; it.vy = vy; it.vz = vz;
        pending_items = {pending_items, it};
    endtask

    task automatic push_random(int n);
        repeat (n) pending_items = {pending_items, random_item()};
    endtask

    initial begin
        filter_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every opcode, field extremes, non-positive innovation variance
        queue_item(pvkf_pkg::OP_ACCEL, 20'd65536, 32'sd65536, -32'sd65536, 32'sd0);
        queue_item(pvkf_pkg::OP_POS, 20'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
        queue_item(pvkf_pkg::OP_VEL, 20'hFFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
        queue_item(pvkf_pkg::OP_ACCEL, 20'hFFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1);
        queue_item(pvkf_pkg::OP_POS, 20'hFFFFF, 32'sd0, 32'sd0, 32'sd0);
        queue_item(pvkf_pkg::OP_INIT, 20'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345);
        queue_item(pvkf_pkg::OP_VEL, 20'd1, 32'sd100, -32'sd100, 32'sd0);
        queue_item(pvkf_pkg::OP_INIT, 20'd0, 32'sd0, 32'sd0, 32'sd0);
        queue_item(pvkf_pkg::OP_POS, 20'd32768, 32'sd65536, 32'sd65536, -32'sd65536);
        wait_drained();
        // zero noise and zero initial variance: innovation variance goes to zero
        configure(31'd0, 31'd0, 31'd0, 31'd0);
        queue_item(pvkf_pkg::OP_INIT, 20'd0, 32'sd5, 32'sd6, 32'sd7);
        queue_item(pvkf_pkg::OP_POS, 20'd0, 32'sd65536, 32'sd0, -32'sd65536);
        queue_item(pvkf_pkg::OP_VEL, 20'd0, 32'sd65536, 32'sd0, -32'sd65536);
        queue_item(pvkf_pkg::OP_ACCEL, 20'd0, 32'sd0, 32'sd0, 32'sd0);
        wait_drained();
        configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_item(pvkf_pkg::OP_INIT, 20'd0, 32'sd1, 32'sd2, 32'sd3);
        queue_item(pvkf_pkg::OP_ACCEL, 20'hFFFFF, 32'sd65536, 32'sd65536, 32'sd65536);
        queue_item(pvkf_pkg::OP_POS, 20'hFFFFF, 32'sd0, 32'sd0, 32'sd0);
        queue_item(pvkf_pkg::OP_VEL, 20'hFFFFF, 32'sd0, 32'sd0, 32'sd0);
        wait_drained();

        // random phases over several settings and idling mixes
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            case (phase)
                0: configure(31'd65536, 31'd65536, 31'd65536, 31'd65536);
                3: configure(31'h7FFF_FFFF, 31'd1, 31'd0, 31'h7FFF_FFFF);
                5: configure(31'd0, 31'd0, 31'd0, 31'd0);
                default: configure(31'($urandom_range(31'h0004_0000)),
                                   31'($urandom_range(31'h0004_0000)),
                                   31'($urandom_range(31'h0001_0000)),
                                   31'($urandom_range(31'h0010_0000)));
            endcase
            queue_item(pvkf_pkg::OP_INIT, 20'd0, rand_value(4), rand_value(4), rand_value(4));
            push_random(115);
            // hold until every pending result is out, then resume
            wait (pending_items.size() == 0);
            wait_drained();
            push_random(115);
            wait_drained();
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pvkf_pkg.sv
rtl/pvkf_alu.sv
rtl/pvkf_div.sv
rtl/position_velocity_kalman_filter_unit.sv
bench/tb_position_velocity_kalman_filter_unit.sv
